/* design/vlr_pkg.sv */
// Shared types and constants for the vertex-level read-modify-write controller.
// Used by vlr_tag_queue, vlr_resolve and vertex_level_rmw_controller; no dependencies.
`default_nettype none

package vlr_pkg;

  localparam int CORE_COUNT    = 8;
  localparam int CORE_SHIFT    = $clog2(CORE_COUNT);
  localparam int PENDING_DEPTH = 16;
  localparam int IDX_W         = $clog2(PENDING_DEPTH);
  localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
  localparam int VERTEX_BITS   = 20;

  localparam int RVTX_W  = 21;
  localparam int LEVEL_W = 17;
  localparam int ITER_W  = 16;
  localparam int DATA_W  = 18;
  localparam int RADDR_W = 18;
  localparam int WADDR_W = 17;

  localparam int IN_W  = 104;
  localparam int OUT_W = 104;

  localparam logic signed [RVTX_W-1:0]  READ_PASS  = -21'sd2;
  localparam logic signed [RADDR_W-1:0] ADDR_PASS  = -18'sd2;
  localparam logic signed [LEVEL_W-1:0] LEVEL_NONE = -17'sd1;
  localparam logic signed [DATA_W-1:0]  DATA_NONE  = -18'sd1;

  typedef struct packed {
    logic                      is_push;
    logic [VERTEX_BITS-1:0]    vertex;
    logic signed [DATA_W-1:0]  level;
    logic                      pull_first;
  } tag_t;

  typedef struct packed {
    logic                       pop;
    logic signed [RADDR_W-1:0]  rd_addr;
    logic                       rd_valid;
    logic                       d_valid;
    logic                       d_push;
    logic [VERTEX_BITS-1:0]     d_vertex;
    logic signed [LEVEL_W-1:0]  d_level;
    logic                       d_pf;
    logic [ITER_W-1:0]          iter;
    logic signed [DATA_W-1:0]   m_data;
    logic                       done;
  } stage_t;

  // The last member lands in the lowest bits, so mem_read_addr starts at bit 0.
  typedef struct packed {
    logic                    iteration_done;
    logic                    active_valid;
    logic                    active_pull_first;
    logic                    active_updated;
    logic [VERTEX_BITS-1:0]  active_vertex;
    logic                    source_level_valid;
    logic [DATA_W-1:0]       source_level;
    logic                    mem_write_valid;
    logic [DATA_W-1:0]       mem_write_level;
    logic [WADDR_W-1:0]      mem_write_addr;
    logic                    mem_read_valid;
    logic [RADDR_W-1:0]      mem_read_addr;
  } result_t;

endpackage

`default_nettype wire

/* design/vlr_tag_queue.sv */
// Pending-read tag FIFO kept in a synchronous memory with a registered head read.
// Depends on vlr_pkg.
`default_nettype none

module vlr_tag_queue
  import vlr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic             pop,
  input  wire logic             push,
  input  wire tag_t             push_tag,
  output logic [CNT_W-1:0]      count,
  output tag_t                  head_tag
);

  tag_t             mem [PENDING_DEPTH];
  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;

  always_ff @(posedge clk) begin
    if (advance) begin
      head_tag <= mem[head];
    end
    if (push) begin
      mem[tail] <= push_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= (head == IDX_W'(PENDING_DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push) begin
        tail <= (tail == IDX_W'(PENDING_DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/vlr_resolve.sv */
// Second stage: compares returned levels against popped tags and forms the result beat.
// Depends on vlr_pkg.
`default_nettype none

module vlr_resolve
  import vlr_pkg::*;
(
  input  wire stage_t  st,
  input  wire tag_t    tag,
  output result_t      res
);

  logic                       pull_wr;
  logic signed [DATA_W-1:0]   d_level_x;
  logic signed [DATA_W-1:0]   iter_x;

  assign pull_wr   = st.d_valid && !st.d_push;
  assign d_level_x = DATA_W'(st.d_level);
  assign iter_x    = $signed({2'b00, st.iter});

  always_comb begin
    res = '0;
    res.mem_read_addr  = st.rd_addr;
    res.mem_read_valid = st.rd_valid;
    res.iteration_done = st.done;
    if (pull_wr) begin
      res.active_vertex     = st.d_vertex;
      res.active_pull_first = st.d_pf;
      res.active_valid      = 1'b1;
      if (st.d_level != LEVEL_NONE && d_level_x <= iter_x) begin
        res.mem_write_addr  = WADDR_W'(st.d_vertex >> CORE_SHIFT);
        res.mem_write_level = d_level_x + DATA_W'(1);
        res.mem_write_valid = 1'b1;
        res.active_updated  = 1'b1;
      end
    end else if (st.pop && tag.is_push) begin
      res.active_vertex     = tag.vertex;
      res.active_pull_first = tag.pull_first;
      res.active_valid      = 1'b1;
      if (st.m_data > tag.level || st.m_data == DATA_NONE) begin
        res.mem_write_addr  = WADDR_W'(tag.vertex >> CORE_SHIFT);
        res.mem_write_level = tag.level;
        res.mem_write_valid = 1'b1;
        res.active_updated  = 1'b1;
      end
    end
    if (st.pop && !tag.is_push) begin
      res.source_level       = st.m_data;
      res.source_level_valid = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* design/vertex_level_rmw_controller.sv */
// Top level of the vertex-level read-modify-write controller: issue stage and output stage.
// Depends on vlr_pkg, vlr_tag_queue and vlr_resolve.
//
//   Port group  Dir  Payload
//   s_*         in   one request/return beat per ready cycle (s_tdata, s_tuser=dst_is_push)
//   m_*         out  one result beat per accepted input beat (m_tdata)
//
// One beat enters per cycle while s_tready is high; its result appears on the following cycle.
// The tag memory read of the queue head is registered in step with the issue stage.
// Reset empties the tag queue at once; tag memory contents are not cleared.
// A stall on m_tready holds the result and stops input only when the output stage is full.
`default_nettype none

module vertex_level_rmw_controller
  import vlr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  // pull_read_valid, pull_read_vertex, dst_valid, dst_vertex, dst_level,
  // dst_pull_first, front_end, iteration_number, mem_data, mem_data_valid
  input  wire logic [IN_W-1:0]  s_tdata,
  // dst_is_push
  input  wire logic             s_tuser,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // mem_read_addr, mem_read_valid, mem_write_addr, mem_write_level,
  // mem_write_valid, source_level, source_level_valid, active_vertex,
  // active_updated, active_pull_first, active_valid, iteration_done
  output logic [OUT_W-1:0]      m_tdata
);

  logic                       rd_req;
  logic signed [RVTX_W-1:0]   rd_vertex;
  logic                       d_valid;
  logic [VERTEX_BITS-1:0]     d_vertex;
  logic signed [LEVEL_W-1:0]  d_level;
  logic                       d_pf;
  logic                       f_end;
  logic [ITER_W-1:0]          iter;
  logic signed [DATA_W-1:0]   m_data;
  logic                       m_valid;

  logic                       advance;
  logic                       pop;
  logic                       push;
  logic                       want_read;
  logic [CNT_W-1:0]           count;
  tag_t                       push_tag;
  tag_t                       head_tag;
  stage_t                     st_next;
  stage_t                     st;
  logic                       out_valid;
  result_t                    res;

  logic signed [RVTX_W:0]     rd_biased;
  logic signed [RVTX_W:0]     rd_quot;
  logic signed [RADDR_W-1:0]  rd_addr;

  assign rd_req    = s_tdata[0];
  assign rd_vertex = $signed(s_tdata[21:1]);
  assign d_valid   = s_tdata[22];
  assign d_vertex  = s_tdata[42:23];
  assign d_level   = $signed(s_tdata[59:43]);
  assign d_pf      = s_tdata[60];
  assign f_end     = s_tdata[61];
  assign iter      = s_tdata[77:62];
  assign m_data    = $signed(s_tdata[95:78]);
  assign m_valid   = s_tdata[96];

  assign s_tready  = !out_valid || m_tready;
  assign advance   = s_tvalid && s_tready;
  assign pop       = advance && m_valid && (count != '0);
  assign want_read = rd_req || (d_valid && s_tuser);
  assign push      = advance && want_read &&
                     ((count != CNT_W'(PENDING_DEPTH)) || pop);

  // Signed division by the core count rounds toward zero.
  assign rd_biased = (RVTX_W + 1)'(rd_vertex) +
                     (rd_vertex[RVTX_W-1] ? (RVTX_W + 1)'(CORE_COUNT - 1) : '0);
  assign rd_quot   = rd_biased >>> CORE_SHIFT;

  always_comb begin
    push_tag = '0;
    rd_addr  = '0;
    if (rd_req) begin
      rd_addr = (rd_vertex == READ_PASS) ? ADDR_PASS : RADDR_W'(rd_quot);
    end else begin
      rd_addr             = $signed(RADDR_W'(d_vertex >> CORE_SHIFT));
      push_tag.is_push    = 1'b1;
      push_tag.vertex     = d_vertex;
      push_tag.level      = DATA_W'(d_level);
      push_tag.pull_first = d_pf;
    end
  end

  always_comb begin
    st_next          = '0;
    st_next.pop      = pop;
    st_next.rd_addr  = push ? rd_addr : '0;
    st_next.rd_valid = push;
    st_next.d_valid  = d_valid;
    st_next.d_push   = s_tuser;
    st_next.d_vertex = d_vertex;
    st_next.d_level  = d_level;
    st_next.d_pf     = d_pf;
    st_next.iter     = iter;
    st_next.m_data   = m_data;
    st_next.done     = f_end && (count == '0);
  end

  vlr_tag_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .pop      (pop),
    .push     (push),
    .push_tag (push_tag),
    .count    (count),
    .head_tag (head_tag)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_tready) begin
      out_valid <= s_tvalid;
    end
  end

  vlr_resolve u_resolve (
    .st  (st),
    .tag (head_tag),
    .res (res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, res};

endmodule

`default_nettype wire

/* tb/sv/vlr_checker.sv */
// Checker for the vertex-level read-modify-write controller: watches both stream ports,
// predicts every result beat from the accepted input beats and compares field by field.
// Depends on vlr_pkg for widths and constants.
module vlr_checker
  import vlr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             s_tuser,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [OUT_W-1:0] m_tdata,
  output int                    fail_count,
  output int                    awaiting,
  output int                    results_checked,
  output int                    level_updates,
  output int                    reads_dropped,
  output int                    iteration_ends
);

  typedef struct {
    logic                      rd_v;
    logic signed [RVTX_W-1:0]  rd_vtx;
    logic                      d_v;
    logic                      d_push;
    logic [VERTEX_BITS-1:0]    d_vtx;
    logic signed [LEVEL_W-1:0] d_lvl;
    logic                      d_pf;
    logic                      f_end;
    logic [ITER_W-1:0]         iter;
    logic signed [DATA_W-1:0]  m_data;
    logic                      m_v;
  } request_t;

  typedef struct {
    logic [RADDR_W-1:0]     rd_addr;
    logic                   rd_v;
    logic [WADDR_W-1:0]     wr_addr;
    logic [DATA_W-1:0]      wr_lvl;
    logic                   wr_v;
    logic [DATA_W-1:0]      src;
    logic                   src_v;
    logic [VERTEX_BITS-1:0] act_vtx;
    logic                   act_upd;
    logic                   act_pf;
    logic                   act_v;
    logic                   done;
  } outcome_t;

  typedef struct {
    logic                     is_push;
    logic [VERTEX_BITS-1:0]   vertex;
    logic signed [DATA_W-1:0] level;
    logic                     pf;
  } pending_tag_t;

  pending_tag_t tag_fifo[$];
  outcome_t     outcome_q[$];
  outcome_t     seen;
  outcome_t     predicted;
  int           mismatch_total = 0;
  int           checked_total = 0;
  int           update_total = 0;
  int           drop_total = 0;
  int           done_total = 0;

  function automatic request_t unpack_request(logic [IN_W-1:0] w, logic push);
    request_t r;
    r.rd_v   = w[0];
    r.rd_vtx = w[21:1];
    r.d_v    = w[22];
    r.d_vtx  = w[42:23];
    r.d_lvl  = w[59:43];
    r.d_pf   = w[60];
    r.f_end  = w[61];
    r.iter   = w[77:62];
    r.m_data = w[95:78];
    r.m_v    = w[96];
    r.d_push = push;
    return r;
  endfunction

  function automatic outcome_t unpack_result(logic [OUT_W-1:0] w);
    outcome_t o;
    o.rd_addr = w[17:0];
    o.rd_v    = w[18];
    o.wr_addr = w[35:19];
    o.wr_lvl  = w[53:36];
    o.wr_v    = w[54];
    o.src     = w[72:55];
    o.src_v   = w[73];
    o.act_vtx = w[93:74];
    o.act_upd = w[94];
    o.act_pf  = w[95];
    o.act_v   = w[96];
    o.done    = w[97];
    return o;
  endfunction

  function automatic outcome_t rmw_outcome(request_t r);
    outcome_t     o;
    pending_tag_t head;
    pending_tag_t fresh;
    int           start_depth;
    bit           pop;
    bit           want;
    bit           room;
    int           lvl;
    int           it;
    int           md;
    int           rv;
    int           hl;
    o = '{default: '0};
    head = '{default: '0};
    fresh = '{default: '0};
    start_depth = tag_fifo.size();
    pop = r.m_v && start_depth > 0;
    if (pop) head = tag_fifo[0];
    want = r.rd_v || (r.d_v && r.d_push);
    room = (start_depth - int'(pop)) < PENDING_DEPTH;
    lvl = r.d_lvl;
    it = r.iter;
    md = r.m_data;
    rv = r.rd_vtx;
    hl = head.level;

    // A pull write owns the write port; a returning push tag then loses its result.
    if (r.d_v && !r.d_push) begin
      o.act_vtx = r.d_vtx;
      o.act_pf = r.d_pf;
      o.act_v = 1'b1;
      if (lvl != -1 && lvl <= it) begin
        o.wr_addr = r.d_vtx / CORE_COUNT;
        o.wr_lvl = lvl + 1;
        o.wr_v = 1'b1;
        o.act_upd = 1'b1;
      end
    end else if (pop && head.is_push) begin
      o.act_vtx = head.vertex;
      o.act_pf = head.pf;
      o.act_v = 1'b1;
      if (md > hl || md == -1) begin
        o.wr_addr = head.vertex / CORE_COUNT;
        o.wr_lvl = head.level;
        o.wr_v = 1'b1;
        o.act_upd = 1'b1;
      end
    end
    if (pop && !head.is_push) begin
      o.src = r.m_data;
      o.src_v = 1'b1;
    end
    if (pop) void'(tag_fifo.pop_front());

    if (want && room) begin
      if (r.rd_v) begin
        o.rd_addr = (rv == -2) ? -2 : rv / CORE_COUNT;
      end else begin
        o.rd_addr = r.d_vtx / CORE_COUNT;
        fresh.is_push = 1'b1;
        fresh.vertex = r.d_vtx;
        fresh.level = r.d_lvl;
        fresh.pf = r.d_pf;
      end
      tag_fifo.push_back(fresh);
      o.rd_v = 1'b1;
    end else if (want) begin
      drop_total++;
    end
    o.done = r.f_end && start_depth == 0;
    if (o.act_upd) update_total++;
    if (o.done) done_total++;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_total++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      tag_fifo.delete();
      outcome_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen = unpack_result(m_tdata);
        if (outcome_q.size() == 0) begin
          mismatch_total++;
          $display("%0t: result beat expected none, got 0x%0h", $time, m_tdata);
        end else begin
          predicted = outcome_q.pop_front();
          check_field("mem_read_addr", predicted.rd_addr, seen.rd_addr);
          check_field("mem_read_valid", predicted.rd_v, seen.rd_v);
          check_field("mem_write_addr", predicted.wr_addr, seen.wr_addr);
          check_field("mem_write_level", predicted.wr_lvl, seen.wr_lvl);
          check_field("mem_write_valid", predicted.wr_v, seen.wr_v);
          check_field("source_level", predicted.src, seen.src);
          check_field("source_level_valid", predicted.src_v, seen.src_v);
          check_field("active_vertex", predicted.act_vtx, seen.act_vtx);
          check_field("active_updated", predicted.act_upd, seen.act_upd);
          check_field("active_pull_first", predicted.act_pf, seen.act_pf);
          check_field("active_valid", predicted.act_v, seen.act_v);
          check_field("iteration_done", predicted.done, seen.done);
          checked_total++;
        end
      end
      if (s_tvalid && s_tready) begin
        outcome_q.push_back(rmw_outcome(unpack_request(s_tdata, s_tuser)));
      end
    end
    fail_count <= mismatch_total;
    awaiting <= outcome_q.size();
    results_checked <= checked_total;
    level_updates <= update_total;
    reads_dropped <= drop_total;
    iteration_ends <= done_total;
  end

endmodule

/* tb/sv/testbench.sv */
// Top of the regression for the vertex-level read-modify-write controller: clock, reset,
// directed and random request beats, receiver back-pressure and the verdict.
// Depends on vlr_pkg, vertex_level_rmw_controller and vlr_checker.
module testbench;
  import vlr_pkg::*;

  typedef struct {
    logic                      rd_v;
    logic signed [RVTX_W-1:0]  rd_vtx;
    logic                      d_v;
    logic                      d_push;
    logic [VERTEX_BITS-1:0]    d_vtx;
    logic signed [LEVEL_W-1:0] d_lvl;
    logic                      d_pf;
    logic                      f_end;
    logic [ITER_W-1:0]         iter;
    logic signed [DATA_W-1:0]  m_data;
    logic                      m_v;
  } vertex_req_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             s_tuser = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  int fail_count;
  int awaiting;
  int results_checked;
  int level_updates;
  int reads_dropped;
  int iteration_ends;

  int tx_idle_pct = 34;
  int rx_idle_pct = 83;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int beats_sent = 0;
  int read_mix[3] = '{85, 20, 50};
  int return_mix[3] = '{10, 90, 50};

  vertex_level_rmw_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  vlr_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .awaiting(awaiting), .results_checked(results_checked),
    .level_updates(level_updates), .reads_dropped(reads_dropped),
    .iteration_ends(iteration_ends)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_asked != hold_taken) begin
      hold_taken++;
      hold_left = 79;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic logic [IN_W-1:0] pack_request(vertex_req_t b);
    logic [IN_W-1:0] w;
    w = '0;
    w[0]     = b.rd_v;
    w[21:1]  = b.rd_vtx;
    w[22]    = b.d_v;
    w[42:23] = b.d_vtx;
    w[59:43] = b.d_lvl;
    w[60]    = b.d_pf;
    w[61]    = b.f_end;
    w[77:62] = b.iter;
    w[95:78] = b.m_data;
    w[96]    = b.m_v;
    return w;
  endfunction

  function automatic vertex_req_t blank();
    vertex_req_t b;
    b = '{default: '0};
    return b;
  endfunction

  function automatic logic signed [LEVEL_W-1:0] pick_level();
    case ($urandom_range(5))
      0: return LEVEL_NONE;
      1, 2, 3: return $urandom_range(24);
      4: return $urandom();
      default: return $urandom_range(1) ? 17'sh0FFFF : 17'sh10000;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_data();
    case ($urandom_range(6))
      0, 1: return DATA_NONE;
      2, 3, 4: return $urandom_range(24);
      5: return $urandom();
      default: begin
        case ($urandom_range(2))
          0: return 18'sh1FFFF;
          1: return 18'sh20000;
          default: return 18'sh10000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [VERTEX_BITS-1:0] pick_vertex();
    case ($urandom_range(3))
      0: return $urandom_range(40);
      1: return $urandom_range(1) ? '1 : '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic signed [RVTX_W-1:0] pick_read_vertex();
    case ($urandom_range(4))
      0: return READ_PASS;
      1: return $urandom_range(40);
      2: return $urandom_range(1048575);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [ITER_W-1:0] pick_iteration();
    case ($urandom_range(4))
      0: return $urandom();
      1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return $urandom_range(24);
    endcase
  endfunction

  function automatic vertex_req_t random_beat(int read_pct, int ret_pct);
    vertex_req_t b;
    int          kind;
    b.rd_vtx = pick_read_vertex();
    b.d_vtx  = pick_vertex();
    b.d_lvl  = pick_level();
    b.d_pf   = $urandom_range(1);
    b.iter   = pick_iteration();
    b.m_data = pick_data();
    b.rd_v   = 1'b0;
    b.d_v    = 1'b0;
    b.d_push = $urandom_range(1);
    kind = $urandom_range(99);
    if (kind < read_pct) begin
      case ($urandom_range(5))
        0, 1: b.rd_v = 1'b1;
        2, 3, 4: begin
          b.d_v = 1'b1;
          b.d_push = 1'b1;
        end
        default: begin
          b.rd_v = 1'b1;
          b.d_v = 1'b1;
          b.d_push = 1'b1;
        end
      endcase
    end else if (kind < read_pct + (100 - read_pct) * 3 / 4) begin
      b.d_v = 1'b1;
      b.d_push = 1'b0;
      b.rd_v = ($urandom_range(3) == 0);
    end
    b.f_end = ($urandom_range(9) == 0);
    b.m_v = ($urandom_range(99) < ret_pct);
    return b;
  endfunction

  task automatic send_beat(vertex_req_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata <= pack_request(b);
    s_tuser <= b.d_push;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    vertex_req_t b;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    b = blank(); b.f_end = 1'b1; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 5; send_beat(b);
    b = blank(); b.rd_v = 1'b1; b.rd_vtx = READ_PASS; send_beat(b);
    b = blank(); b.rd_v = 1'b1; b.rd_vtx = 21'sd1048575;
    b.d_v = 1'b1; b.d_push = 1'b1; b.d_vtx = 77; b.d_lvl = 3; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_push = 1'b1; b.d_vtx = '1;
    b.d_lvl = LEVEL_NONE; b.d_pf = 1'b1; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_push = 1'b1; b.d_lvl = 5; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_push = 1'b1; b.d_vtx = 12345;
    b.d_lvl = 7; b.d_pf = 1'b1; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_push = 1'b1; b.d_vtx = 99; b.d_lvl = 3; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_push = 1'b1; b.d_vtx = 8; b.d_lvl = 17'sh0FFFF;
    send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 42; b.f_end = 1'b1; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = DATA_NONE;
    b.rd_v = 1'b1; b.rd_vtx = -21'sd9; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = DATA_NONE; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 9; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 7; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 1;
    b.d_v = 1'b1; b.d_vtx = 500; b.d_lvl = 2; b.iter = 2; b.d_pf = 1'b1; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 18'sh1FFFF; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 18'sh20000; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_lvl = LEVEL_NONE; b.iter = 16'hFFFF; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_vtx = 31; b.d_lvl = 10; b.iter = 9; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_vtx = 16; send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_vtx = '1; b.d_lvl = 17'sh0FFFF; b.iter = 16'hFFFF;
    send_beat(b);
    b = blank(); b.d_v = 1'b1; b.d_lvl = 17'sh10000; send_beat(b);
    b = blank(); b.rd_v = 1'b1; b.rd_vtx = 21'sh100000; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 18'sh10000; send_beat(b);
    b = blank(); b.m_v = 1'b1; b.m_data = 3; b.f_end = 1'b1; send_beat(b);
    wait_drained();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 34; rx_idle_pct = 83; end
        1: begin tx_idle_pct = 83; rx_idle_pct = 34; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_asked++;
        end
      endcase
      for (int seg = 0; seg < 10; seg++) begin
        for (int i = 0; i < 35; i++) begin
          send_beat(random_beat(read_mix[seg % 3], return_mix[seg % 3]));
        end
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("Sent %0d beats and checked %0d results under three back-pressure mixes.",
             beats_sent, results_checked);
    $display("Seen: %0d level updates, %0d reads dropped on a full tag queue, %0d iteration ends.",
             level_updates, reads_dropped, iteration_ends);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
